// ===== rtl/tlaas_pkg.sv =====
// ----------------------------------------------------------------------------
// Three-link arm angle search: shared package
// Register indexes, reset values, default parameters, sine table builder and
// angle wrap helper.
// ----------------------------------------------------------------------------
package tlaas_pkg;

    // default parameters
    localparam int LINK1_LEN_DEF      = 8;
    localparam int LINK2_LEN_DEF      = 6;
    localparam int LINK3_LEN_DEF      = 15;
    localparam int ANGLE_STEP_DEF     = 1;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    // configuration register indexes
    localparam logic [2:0] REG_J1_MIN = 3'd0;
    localparam logic [2:0] REG_J1_MAX = 3'd1;
    localparam logic [2:0] REG_J2_MIN = 3'd2;
    localparam logic [2:0] REG_J2_MAX = 3'd3;
    localparam logic [2:0] REG_J3_MIN = 3'd4;
    localparam logic [2:0] REG_J3_MAX = 3'd5;
    localparam logic [2:0] REG_RX_MIN = 3'd6;
    localparam logic [2:0] REG_RX_MAX = 3'd7;

    // register reset values
    localparam logic [7:0] J1_MIN_RST = 8'd25;
    localparam logic [7:0] J1_MAX_RST = 8'd166;
    localparam logic [7:0] J2_MIN_RST = 8'd30;
    localparam logic [7:0] J2_MAX_RST = 8'd175;
    localparam logic [7:0] J3_MIN_RST = 8'd30;
    localparam logic [7:0] J3_MAX_RST = 8'd175;
    localparam logic [5:0] RX_MIN_RST = 6'd4;
    localparam logic [5:0] RX_MAX_RST = 6'd33;

    // quarter-wave sine table, unsigned, wide enough for 20 fraction bits
    localparam int SINE_W = 21;
    typedef logic [SINE_W-1:0] t_sine_rom [0:90];

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned div_u64(input longint unsigned n,
                                                input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Taylor series in Q30 with truncating products, rounded half up to frac bits
    function automatic t_sine_rom build_sine(input int frac);
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   term;
        longint unsigned   dv;
        longint            sum;
        for (int k = 0; k <= 90; k++) begin
            x    = div_u64(longint'(k) * PI_Q30 + 64'd90, 64'd180);
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                dv   = longint'((2 * n) * (2 * n + 1));
                term = div_u64(term, dv);
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            rom[k] = SINE_W'((longint'(sum) + (longint'(1) << (29 - frac))) >> (30 - frac));
        end
        return rom;
    endfunction

    // add a small signed offset to an angle in 0..359 and fold back into 0..359
    function automatic logic [8:0] wrap_add(input logic [8:0] w, input logic signed [9:0] d);
        logic signed [10:0] s;
        s = $signed({2'b00, w}) + 11'(d);
        if (s < 0) begin
            s = s + 11'sd360;
        end else if (s >= 11'sd360) begin
            s = s - 11'sd360;
        end
        return s[8:0];
    endfunction

endpackage

// ===== rtl/three_link_arm_angle_search.sv =====
// ----------------------------------------------------------------------------
// Three-link arm angle search
// Brute-force search of joint angles for a planar three-link arm.
// ----------------------------------------------------------------------------
// Sequence: the divider computes the start angle, which is then folded into
//   0..359; each tested pose is evaluated state by state, with extra steps per second-joint
//   angle and per base angle (one more at the turn), and a closing state before the result beat.
// Throughput: one item at a time; busy drops in the cycle of the result beat.
// The result is shown for one cycle on o_strobe; the receiver cannot stall.
// Reset: synchronous, active low; registers return to defaults, search goes idle.
module three_link_arm_angle_search #(
    parameter int LINK1_LEN      = tlaas_pkg::LINK1_LEN_DEF,
    parameter int LINK2_LEN      = tlaas_pkg::LINK2_LEN_DEF,
    parameter int LINK3_LEN      = tlaas_pkg::LINK3_LEN_DEF,
    parameter int ANGLE_STEP     = tlaas_pkg::ANGLE_STEP_DEF,
    parameter int TRIG_FRAC_BITS = tlaas_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic signed [6:0] i_target_x,
    input  logic signed [6:0] i_target_y,
    output logic              o_busy,
    output logic              o_strobe,
    output logic signed [8:0] o_base_angle,
    output logic signed [8:0] o_elbow_angle,
    output logic signed [8:0] o_wrist_angle,
    output logic              o_found,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);

    localparam int F  = TRIG_FRAC_BITS;
    localparam int MW = F + 2;      // multiplier operand, signed
    localparam int PW = F + 9;      // positions and errors, signed
    localparam int SW = 2 * F + 1;  // squared error sum
    localparam int AW = 18;         // raw angles, signed

    localparam tlaas_pkg::t_sine_rom SINE_ROM = tlaas_pkg::build_sine(F);

    localparam logic signed [9:0]    STEP = 10'(ANGLE_STEP);
    localparam logic signed [PW-1:0] LIM  = PW'(1) <<< F;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DIV     = 5'd1;
    localparam logic [4:0] S_WRAP    = 5'd2;
    localparam logic [4:0] S_B_COS   = 5'd3;
    localparam logic [4:0] S_B_SIN   = 5'd4;
    localparam logic [4:0] S_E_COS   = 5'd5;
    localparam logic [4:0] S_E_SIN   = 5'd6;
    localparam logic [4:0] S_T_COS   = 5'd7;
    localparam logic [4:0] S_T_SIN   = 5'd8;
    localparam logic [4:0] S_SQX     = 5'd9;
    localparam logic [4:0] S_SQY     = 5'd10;
    localparam logic [4:0] S_CMP     = 5'd11;
    localparam logic [4:0] S_NEXT_J  = 5'd12;
    localparam logic [4:0] S_NEXT_I  = 5'd13;
    localparam logic [4:0] S_SWEEP   = 5'd14;
    localparam logic [4:0] S_NEXT_A1 = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    // configuration
    logic [7:0] r_j1min, r_j1max, r_j2min, r_j2max, r_j3min, r_j3max;
    logic [5:0] r_rxmin, r_rxmax;

    // search state
    logic [4:0]           r_state;
    logic signed [PW-1:0] r_tx, r_ty;
    logic signed [AW-1:0] r_a1, r_start, r_red;
    logic [8:0]           r_w1, r_wstart, r_w2, r_w3;
    logic signed [9:0]    r_i, r_j;
    logic                 r_down, r_init, r_hit, r_far, r_neg;
    logic signed [PW-1:0] r_bx, r_by, r_ex, r_ey, r_dx, r_dy;
    logic [SW-1:0]        r_sq;

    // result
    logic              r_strobe, r_found;
    logic signed [8:0] r_base, r_elbow, r_wrist;

    // start angle arithmetic
    logic signed [8:0]  dj1;
    logic signed [15:0] num;
    logic [13:0]        num_mag;
    logic signed [6:0]  span;
    logic               div_done;
    logic [13:0]        div_quo;
    logic [5:0]         div_rem;
    logic signed [AW-1:0] quo_s, start_c;

    // shared multiplier and trig lookup
    logic [8:0]             trig_ang;
    logic                   trig_cos;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    logic signed [PW-1:0]   prod_p;
    logic                   dx_near, dy_near;
    logic [SW+6:0]          sq100;
    logic                   pose_hit;

    // result check
    logic signed [AW-1:0] j1min_s, j1max_s, j2min_s, j2max_s, j3min_s, j3max_s;
    logic signed [AW-1:0] a2_raw, a3_raw, r2, r3;
    logic                 in_lim;

    // next-step helpers
    logic signed [AW-1:0] a1_up, a1_dn;
    logic signed [9:0]    j_nx, i_nx;

    function automatic logic signed [MW-1:0] trig_val(input logic [8:0] r);
        logic [8:0]           t;
        logic                 neg;
        logic signed [MW-1:0] m;
        if (r <= 9'd90) begin
            t = r;              neg = 1'b0;
        end else if (r <= 9'd180) begin
            t = 9'd180 - r;     neg = 1'b0;
        end else if (r <= 9'd270) begin
            t = r - 9'd180;     neg = 1'b1;
        end else begin
            t = 9'd360 - r;     neg = 1'b1;
        end
        m = MW'(SINE_ROM[t[6:0]]);
        return neg ? -m : m;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j1min <= tlaas_pkg::J1_MIN_RST;
            r_j1max <= tlaas_pkg::J1_MAX_RST;
            r_j2min <= tlaas_pkg::J2_MIN_RST;
            r_j2max <= tlaas_pkg::J2_MAX_RST;
            r_j3min <= tlaas_pkg::J3_MIN_RST;
            r_j3max <= tlaas_pkg::J3_MAX_RST;
            r_rxmin <= tlaas_pkg::RX_MIN_RST;
            r_rxmax <= tlaas_pkg::RX_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlaas_pkg::REG_J1_MIN: r_j1min <= i_cfg_data;
                tlaas_pkg::REG_J1_MAX: r_j1max <= i_cfg_data;
                tlaas_pkg::REG_J2_MIN: r_j2min <= i_cfg_data;
                tlaas_pkg::REG_J2_MAX: r_j2max <= i_cfg_data;
                tlaas_pkg::REG_J3_MIN: r_j3min <= i_cfg_data;
                tlaas_pkg::REG_J3_MAX: r_j3max <= i_cfg_data;
                tlaas_pkg::REG_RX_MIN: r_rxmin <= i_cfg_data[5:0];
                tlaas_pkg::REG_RX_MAX: r_rxmax <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // start angle: floor(j1max - dj1 * x / span)
    assign dj1     = $signed({1'b0, r_j1max}) - $signed({1'b0, r_j1min});
    assign num     = -(16'(dj1) * 16'(i_target_x));
    assign num_mag = num[15] ? 14'(-num) : num[13:0];
    assign span    = $signed({1'b0, r_rxmax}) - $signed({1'b0, r_rxmin});

    tlaas_div #(
        .NUM_W (14),
        .DEN_W (6)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start && (r_state == S_IDLE) && (span > 0)),
        .i_num   (num_mag),
        .i_den   (span[5:0]),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign quo_s   = r_neg ? (-AW'(div_quo) - AW'(div_rem != 6'd0)) : AW'(div_quo);
    assign start_c = $signed({10'd0, r_j1max}) + quo_s;

    // shared multiplier operands
    always_comb begin
        trig_cos = 1'b0;
        trig_ang = r_w1;
        mul_a    = MW'(LINK1_LEN);
        case (r_state)
            S_B_COS: begin trig_ang = r_w1; trig_cos = 1'b1; mul_a = MW'(LINK1_LEN); end
            S_B_SIN: begin trig_ang = r_w1; trig_cos = 1'b0; mul_a = MW'(LINK1_LEN); end
            S_E_COS: begin trig_ang = r_w2; trig_cos = 1'b1; mul_a = MW'(LINK2_LEN); end
            S_E_SIN: begin trig_ang = r_w2; trig_cos = 1'b0; mul_a = MW'(LINK2_LEN); end
            S_T_COS: begin trig_ang = r_w3; trig_cos = 1'b1; mul_a = MW'(LINK3_LEN); end
            S_T_SIN: begin trig_ang = r_w3; trig_cos = 1'b0; mul_a = MW'(LINK3_LEN); end
            S_SQX:   mul_a = r_dx[MW-1:0];
            S_SQY:   mul_a = r_dy[MW-1:0];
            default: ;
        endcase
        if (r_state == S_SQX) begin
            mul_b = r_dx[MW-1:0];
        end else if (r_state == S_SQY) begin
            mul_b = r_dy[MW-1:0];
        end else begin
            mul_b = trig_val(trig_cos ? tlaas_pkg::wrap_add(trig_ang, 10'sd90) : trig_ang);
        end
    end

    assign prod    = mul_a * mul_b;
    assign prod_p  = PW'(prod);
    assign dx_near = (r_dx > -LIM) && (r_dx < LIM);
    assign dy_near = (r_dy > -LIM) && (r_dy < LIM);
    assign sq100   = ({7'd0, r_sq} << 6) + ({7'd0, r_sq} << 5) + ({7'd0, r_sq} << 2);
    assign pose_hit = !r_far && (sq100 < ((SW+7)'(1) << (2 * F)));

    assign j1min_s = $signed({10'd0, r_j1min});
    assign j1max_s = $signed({10'd0, r_j1max});
    assign j2min_s = $signed({10'd0, r_j2min});
    assign j2max_s = $signed({10'd0, r_j2max});
    assign j3min_s = $signed({10'd0, r_j3min});
    assign j3max_s = $signed({10'd0, r_j3max});

    assign a2_raw = r_init ? j2min_s : (r_a1 - AW'(r_i));
    assign a3_raw = r_init ? j3min_s : (a2_raw - AW'(r_j));
    assign r2     = AW'(180) - r_a1 + a2_raw;
    assign r3     = AW'(180) - a2_raw + a3_raw;
    assign in_lim = (r_a1 >= j1min_s) && (r_a1 <= j1max_s) && (r2 >= j2min_s)
                 && (r2 <= j2max_s) && (r3 >= j3min_s) && (r3 <= j3max_s);

    assign a1_up = r_a1 + AW'(STEP);
    assign a1_dn = r_a1 - AW'(STEP);
    assign j_nx  = r_j + STEP;
    assign i_nx  = r_i - STEP;

    // search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_down   <= 1'b0;
            r_init   <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_tx  <= PW'(i_target_x) <<< F;
                        r_ty  <= PW'(i_target_y) <<< F;
                        r_neg <= num[15];
                        r_hit <= 1'b0;
                        r_state <= (span > 0) ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_start <= start_c;
                        r_a1    <= start_c;
                        r_red   <= start_c;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    // reduce the start angle into 0..359
                    if (r_red < 0) begin
                        r_red <= r_red + AW'(360);
                    end else if (r_red >= AW'(360)) begin
                        r_red <= r_red - AW'(360);
                    end else begin
                        r_w1     <= r_red[8:0];
                        r_wstart <= r_red[8:0];
                        r_w2     <= {1'b0, r_j2min};
                        r_w3     <= {1'b0, r_j3min};
                        r_init   <= 1'b1;
                        r_down   <= 1'b0;
                        r_state  <= S_B_COS;
                    end
                end
                S_B_COS: begin r_bx <= prod_p; r_state <= S_B_SIN; end
                S_B_SIN: begin r_by <= prod_p; r_state <= S_E_COS; end
                S_E_COS: begin r_ex <= r_bx + prod_p; r_state <= S_E_SIN; end
                S_E_SIN: begin
                    r_ey <= r_by + prod_p;
                    if (r_init) begin
                        r_state <= S_T_COS;
                    end else begin
                        r_j  <= $signed({2'b00, r_j3min});
                        r_w3 <= tlaas_pkg::wrap_add(r_w2, -$signed({2'b00, r_j3min}));
                        r_state <= (r_j3min < r_j3max) ? S_T_COS : S_NEXT_I;
                    end
                end
                S_T_COS: begin r_dx <= r_tx - (r_ex + prod_p); r_state <= S_T_SIN; end
                S_T_SIN: begin r_dy <= r_ty - (r_ey + prod_p); r_state <= S_SQX; end
                S_SQX: begin
                    r_far   <= !dx_near;
                    r_sq    <= SW'(prod);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_far   <= r_far || !dy_near;
                    r_sq    <= r_sq + SW'(prod);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (pose_hit) begin
                        r_hit   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_init) begin
                        r_init  <= 1'b0;
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= S_NEXT_J;
                    end
                end
                S_NEXT_J: begin
                    r_j  <= j_nx;
                    r_w3 <= tlaas_pkg::wrap_add(r_w3, -STEP);
                    r_state <= (j_nx < $signed({2'b00, r_j3max})) ? S_T_COS : S_NEXT_I;
                end
                S_NEXT_I: begin
                    r_i  <= i_nx;
                    r_w2 <= tlaas_pkg::wrap_add(r_w2, STEP);
                    r_state <= (i_nx > $signed({2'b00, r_j2min})) ? S_E_COS : S_NEXT_A1;
                end
                S_SWEEP: begin
                    r_i  <= $signed({2'b00, r_j2max});
                    r_w2 <= tlaas_pkg::wrap_add(r_w1, -$signed({2'b00, r_j2max}));
                    r_state <= (r_j2max > r_j2min) ? S_B_COS : S_NEXT_A1;
                end
                S_NEXT_A1: begin
                    if (!r_down) begin
                        if (a1_up > j1max_s) begin
                            // return to the start and turn round; start is already done
                            r_down <= 1'b1;
                            r_a1   <= r_start;
                            r_w1   <= r_wstart;
                            if (r_start < j1min_s) begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_a1 <= a1_up;
                            r_w1 <= tlaas_pkg::wrap_add(r_w1, STEP);
                            r_state <= (a1_up < j1min_s) ? S_DONE : S_SWEEP;
                        end
                    end else begin
                        r_a1 <= a1_dn;
                        r_w1 <= tlaas_pkg::wrap_add(r_w1, -STEP);
                        r_state <= ((a1_dn > j1max_s) || (a1_dn < j1min_s)) ? S_DONE : S_SWEEP;
                    end
                end
                S_DONE: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            if (r_hit && in_lim) begin
                r_base  <= r_a1[8:0];
                r_elbow <= r2[8:0];
                r_wrist <= r3[8:0];
                r_found <= 1'b1;
            end else begin
                r_base  <= -9'sd1;
                r_elbow <= -9'sd1;
                r_wrist <= -9'sd1;
                r_found <= 1'b0;
            end
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_base_angle  = r_base;
    assign o_elbow_angle = r_elbow;
    assign o_wrist_angle = r_wrist;
    assign o_found       = r_found;

endmodule

// ===== rtl/tlaas_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned numerator by unsigned denominator, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlaas_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/tlaas_chk.sv =====
// ----------------------------------------------------------------------------
// Three-link arm angle search: port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module tlaas_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic signed [6:0] i_target_x,
    input logic signed [6:0] i_target_y,
    input logic              o_busy,
    input logic              o_strobe,
    input logic signed [8:0] o_base_angle,
    input logic signed [8:0] o_elbow_angle,
    input logic signed [8:0] o_wrist_angle,
    input logic              o_found,
    input logic              i_cfg_we,
    input logic [2:0]        i_cfg_idx,
    input logic [7:0]        i_cfg_data
);

    // an accepted beat keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted beat did not raise busy");

    // the result beat only appears once the search has finished
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("result beat while busy");

    // finishing a search always delivers exactly one beat
    a_fall_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_strobe)
        else $error("search ended without a result beat");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beat repeated");

    // a miss reports all angles as -1
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_found |-> (o_base_angle == -9'sd1) && (o_elbow_angle == -9'sd1)
            && (o_wrist_angle == -9'sd1))
        else $error("miss with angles other than -1");

endmodule

bind three_link_arm_angle_search tlaas_chk u_tlaas_chk (.*);
